FILE: rtl/cab_pkg.sv
// shared types, constants and helpers of the clipped alpha blitter
package cab_pkg;

    localparam int XY_W    = 13;
    localparam int PIX_W   = 32;
    localparam int ADDR_W  = 24;
    localparam int CH_W    = 8;
    localparam int PROD_W  = 2 * CH_W;
    localparam int IDX_W   = 3;
    localparam int Q_PTR_W = 2;
    localparam int Q_DEPTH = 1 << Q_PTR_W;

    localparam logic [CH_W-1:0] CH_MAX = 8'hff;

    typedef enum logic [IDX_W-1:0] {
        REG_DEST_WIDTH  = 3'd0,
        REG_DEST_HEIGHT = 3'd1,
        REG_PLACE_X     = 3'd2,
        REG_PLACE_Y     = 3'd3,
        REG_SRC_WIDTH   = 3'd4,
        REG_SRC_HEIGHT  = 3'd5,
        REG_BLIT_MODE   = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_COPY  = 2'd0,
        MODE_BLEND = 2'd1,
        MODE_KEYED = 2'd2
    } blit_mode_t;

    // one classified pixel waiting for the back end
    typedef struct packed {
        logic              we;
        logic              blend;
        logic              last;
        logic [XY_W-1:0]   x;
        logic [XY_W-1:0]   y;
        logic [PIX_W-1:0]  src;
        logic [PIX_W-1:0]  dst;
    } cab_job_t;

    // exact floor(v / 255) for v up to 255 * 255
    function automatic logic [CH_W-1:0] div255(input logic [PROD_W-1:0] v);
        logic [PROD_W:0] s;
        s = {1'b0, v} + (PROD_W+1)'(v[PROD_W-1:CH_W]) + (PROD_W+1)'(1);
        return s[PROD_W-1:CH_W];
    endfunction

endpackage

FILE: rtl/cab_if.sv
// request channels of the clipped alpha blitter
interface cab_in_if import cab_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] src_pixel;
    logic [PIX_W-1:0] dst_pixel;

    modport source (output valid, output src_pixel, output dst_pixel, input ready);
    modport sink (input valid, input src_pixel, input dst_pixel, output ready);
endinterface

interface cab_out_if import cab_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              write_enable;
    logic [ADDR_W-1:0] dest_address;
    logic [PIX_W-1:0]  out_pixel;
    logic              last;

    modport source (output valid, output write_enable, output dest_address,
                    output out_pixel, output last, input ready);
    modport sink (input valid, input write_enable, input dest_address,
                  input out_pixel, input last, output ready);
endinterface

FILE: rtl/cab_queue.sv
// small fifo between the front end and the back end
module cab_queue import cab_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  cab_job_t push_job,
    output logic     full,
    input  logic     pop,
    output cab_job_t pop_job,
    output logic     empty
);

    cab_job_t             mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_PTR_W:0]     count_reg, count_next;

    assign full    = (count_reg == (Q_PTR_W+1)'(Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (Q_PTR_W+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (Q_PTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: rtl/cab_front.sv
// register bank, rectangle counters and clip/key classification
module cab_front import cab_pkg::*;
#(
    parameter int MAX_DIM = 4096,
    parameter int DIM_W   = 13
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [XY_W-1:0]  cfg_data,
    cab_in_if.sink           pix_in,
    input  logic             q_full,
    output logic             q_push,
    output cab_job_t         q_job,
    output logic [DIM_W-1:0] dw
);

    localparam int CNT_W = $clog2(MAX_DIM);
    localparam int CMP_W = DIM_W + 1;
    localparam int SUM_W = ((CNT_W > XY_W) ? CNT_W : XY_W) + 2;
    localparam logic [XY_W:0]    MAX_DIM_X = (XY_W+1)'(MAX_DIM);
    localparam logic [DIM_W-1:0] DW_RST = DIM_W'((MAX_DIM < 1024) ? MAX_DIM : 1024);
    localparam logic [DIM_W-1:0] DH_RST = DIM_W'((MAX_DIM < 768) ? MAX_DIM : 768);
    localparam logic [DIM_W-1:0] SW_RST = DIM_W'((MAX_DIM < 16) ? MAX_DIM : 16);

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [XY_W-1:0] v);
        logic [XY_W:0] ve;
        ve = {1'b0, v};
        if (v == '0)
        begin
            return DIM_W'(1);
        end
        else if (ve > MAX_DIM_X)
        begin
            return DIM_W'(MAX_DIM);
        end
        return DIM_W'(v);
    endfunction

    logic [DIM_W-1:0] dw_reg, dw_next, dh_reg, dh_next;
    logic [DIM_W-1:0] sw_reg, sw_next, sh_reg, sh_next;
    logic [XY_W-1:0]  px_reg, px_next, py_reg, py_next;
    blit_mode_t       mode_reg, mode_next;
    logic [CNT_W-1:0] col_reg, col_next, row_reg, row_next;

    logic             cfg_hit;
    logic             accept;
    logic [CMP_W-1:0] col_inc, row_inc;
    logic             col_wrap, row_wrap;
    logic [SUM_W-1:0] cx, cy;
    logic             on_surface, keyed_out;

    assign pix_in.ready = !q_full;
    assign accept       = pix_in.valid && !q_full;
    assign dw           = dw_reg;

    // register writes
    always_comb
    begin
        dw_next   = dw_reg;
        dh_next   = dh_reg;
        px_next   = px_reg;
        py_next   = py_reg;
        sw_next   = sw_reg;
        sh_next   = sh_reg;
        mode_next = mode_reg;
        cfg_hit   = 1'b0;
        if (cfg_we)
        begin
            cfg_hit = 1'b1;
            unique case (cfg_reg_t'(cfg_index))
                REG_DEST_WIDTH:  dw_next   = clamp_dim(cfg_data);
                REG_DEST_HEIGHT: dh_next   = clamp_dim(cfg_data);
                REG_PLACE_X:     px_next   = cfg_data;
                REG_PLACE_Y:     py_next   = cfg_data;
                REG_SRC_WIDTH:   sw_next   = clamp_dim(cfg_data);
                REG_SRC_HEIGHT:  sh_next   = clamp_dim(cfg_data);
                REG_BLIT_MODE:   mode_next = blit_mode_t'(cfg_data[1:0]);
                default:         cfg_hit   = 1'b0;
            endcase
        end
    end

    // raster position inside the rectangle, restarted by any register write
    always_comb
    begin
        col_inc  = CMP_W'(col_reg) + CMP_W'(1);
        row_inc  = CMP_W'(row_reg) + CMP_W'(1);
        col_wrap = (col_inc >= CMP_W'(sw_reg));
        row_wrap = (row_inc >= CMP_W'(sh_reg));
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_hit)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (col_wrap)
            begin
                col_next = '0;
                row_next = row_wrap ? '0 : row_inc[CNT_W-1:0];
            end
            else
            begin
                col_next = col_inc[CNT_W-1:0];
            end
        end
    end

    // a negative position reads as a huge unsigned value, so one compare clips both sides
    always_comb
    begin
        cx         = SUM_W'($signed(px_reg)) + SUM_W'(col_reg);
        cy         = SUM_W'($signed(py_reg)) + SUM_W'(row_reg);
        on_surface = (cx < SUM_W'(dw_reg)) && (cy < SUM_W'(dh_reg));
        keyed_out  = (mode_reg == MODE_KEYED) && (pix_in.src_pixel[PIX_W-1 -: CH_W] == '0);

        q_push      = accept;
        q_job.we    = on_surface && !keyed_out;
        q_job.blend = (mode_reg == MODE_BLEND);
        q_job.last  = col_wrap && row_wrap;
        q_job.x     = cx[XY_W-1:0];
        q_job.y     = cy[XY_W-1:0];
        q_job.src   = pix_in.src_pixel;
        q_job.dst   = pix_in.dst_pixel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dw_reg   <= DW_RST;
            dh_reg   <= DH_RST;
            px_reg   <= '0;
            py_reg   <= '0;
            sw_reg   <= SW_RST;
            sh_reg   <= SW_RST;
            mode_reg <= MODE_COPY;
            col_reg  <= '0;
            row_reg  <= '0;
        end
        else
        begin
            dw_reg   <= dw_next;
            dh_reg   <= dh_next;
            px_reg   <= px_next;
            py_reg   <= py_next;
            sw_reg   <= sw_next;
            sh_reg   <= sh_next;
            mode_reg <= mode_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
        end
    end

endmodule

FILE: rtl/cab_back.sv
// two-stage datapath: multiplies, then blend divide, address add and output register
module cab_back import cab_pkg::*;
#(
    parameter int DIM_W = 13
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             job_valid,
    input  cab_job_t         job,
    output logic             job_pop,
    input  logic [DIM_W-1:0] dw,
    cab_out_if.source        pix_out
);

    localparam int YP_W = XY_W + DIM_W;

    logic advance;

    // stage 1
    logic               s1_valid_reg, s1_valid_next;
    logic               s1_we_reg, s1_we_next;
    logic               s1_blend_reg, s1_blend_next;
    logic               s1_last_reg, s1_last_next;
    logic [XY_W-1:0]    s1_x_reg, s1_x_next;
    logic [ADDR_W-1:0]  s1_base_reg, s1_base_next;
    logic [PIX_W-1:0]   s1_src_reg, s1_src_next;
    logic [PROD_W-1:0]  s1_ps_reg [3];
    logic [PROD_W-1:0]  s1_ps_next [3];
    logic [PROD_W-1:0]  s1_pd_reg [3];
    logic [PROD_W-1:0]  s1_pd_next [3];

    // output stage
    logic               out_valid_reg, out_valid_next;
    logic               out_we_reg, out_we_next;
    logic [ADDR_W-1:0]  out_addr_reg, out_addr_next;
    logic [PIX_W-1:0]   out_pix_reg, out_pix_next;
    logic               out_last_reg, out_last_next;

    logic [YP_W-1:0]    y_prod;
    logic [CH_W-1:0]    alpha;
    logic [CH_W-1:0]    mix [3];
    logic [PIX_W-1:0]   blended;

    assign advance = !out_valid_reg || pix_out.ready;
    assign job_pop = advance && job_valid;

    always_comb
    begin
        alpha         = job.src[PIX_W-1 -: CH_W];
        y_prod        = YP_W'(job.y) * YP_W'(dw);
        s1_valid_next = advance ? job_valid : s1_valid_reg;
        s1_we_next    = job.we;
        s1_blend_next = job.blend;
        s1_last_next  = job.last;
        s1_x_next     = job.x;
        s1_base_next  = ADDR_W'(y_prod);
        s1_src_next   = job.src;
        for (int k = 0; k < 3; k++)
        begin
            s1_ps_next[k] = PROD_W'(alpha) * PROD_W'(job.src[k*CH_W +: CH_W]);
            s1_pd_next[k] = PROD_W'(CH_MAX - alpha) * PROD_W'(job.dst[k*CH_W +: CH_W]);
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            mix[k] = div255(s1_ps_reg[k] + s1_pd_reg[k]);
        end
        blended        = {CH_MAX, mix[2], mix[1], mix[0]};
        out_valid_next = advance ? s1_valid_reg : out_valid_reg;
        out_we_next    = s1_we_reg;
        out_last_next  = s1_last_reg;
        out_addr_next  = '0;
        out_pix_next   = '0;
        if (s1_we_reg)
        begin
            out_addr_next = s1_base_reg + ADDR_W'(s1_x_reg);
            out_pix_next  = s1_blend_reg ? blended : s1_src_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            s1_we_reg    <= s1_we_next;
            s1_blend_reg <= s1_blend_next;
            s1_last_reg  <= s1_last_next;
            s1_x_reg     <= s1_x_next;
            s1_base_reg  <= s1_base_next;
            s1_src_reg   <= s1_src_next;
            s1_ps_reg    <= s1_ps_next;
            s1_pd_reg    <= s1_pd_next;
        end
        if (advance && s1_valid_reg)
        begin
            out_we_reg   <= out_we_next;
            out_addr_reg <= out_addr_next;
            out_pix_reg  <= out_pix_next;
            out_last_reg <= out_last_next;
        end
    end

    assign pix_out.valid        = out_valid_reg;
    assign pix_out.write_enable = out_we_reg;
    assign pix_out.dest_address = out_addr_reg;
    assign pix_out.out_pixel    = out_pix_reg;
    assign pix_out.last         = out_last_reg;

endmodule

FILE: rtl/clipped_alpha_blitter_top.sv
// top level of the clipped ARGB8888 alpha blitter
// usage:
//   pix_in carries one request per source pixel of the rectangle, in raster
//   order, together with the destination pixel now at that spot
//   pix_out returns one request per input: write enable, destination address,
//   pixel to write and a last flag on the final pixel of the rectangle
//   the cfg port (cfg_we, cfg_index, cfg_data) writes the seven registers;
//   write only while no request is in flight; any write to registers 0..6
//   restarts the rectangle at its top left corner, index 7 is ignored
// timing:
//   one request per clock sustained while pix_out stays ready; a taken input passes
//   through a queue slot, the multiply stage and the output register
//   the front end takes input whenever its four-entry queue has room, so it
//   keeps accepting while a finished result waits on pix_out
// stall and reset:
//   when pix_out is not ready the back end holds, the queue fills and then
//   pix_in.ready drops; nothing is lost or repeated
//   reset empties the pipe, restores the register defaults and zeroes the
//   row and column counters
module clipped_alpha_blitter_top import cab_pkg::*;
#(
    parameter int MAX_DIM = 4096
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [XY_W-1:0]  cfg_data,
    cab_in_if.sink           pix_in,
    cab_out_if.source        pix_out
);

    // sizes are clamped to MAX_DIM, so they need enough bits to hold MAX_DIM itself
    localparam int DIM_W = $clog2(MAX_DIM + 1);

    logic             q_full;
    logic             q_empty;
    logic             q_push;
    logic             q_pop;
    cab_job_t         push_job;
    cab_job_t         pop_job;
    logic [DIM_W-1:0] dw;

    // front end: registers, counters, clip and color-key decision
    cab_front #(
        .MAX_DIM (MAX_DIM),
        .DIM_W   (DIM_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_in    (pix_in),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (push_job),
        .dw        (dw)
    );

    // decouples input acceptance from output stalls
    cab_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    // back end: address multiply and per-channel blend
    cab_back #(
        .DIM_W (DIM_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (!q_empty),
        .job       (pop_job),
        .job_pop   (q_pop),
        .dw        (dw),
        .pix_out   (pix_out)
    );

endmodule

FILE: rtl/cab_checker.sv
// port-level assertions for the blitter top and their bind
module cab_checker import cab_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic              out_we,
    input logic [ADDR_W-1:0] out_addr,
    input logic [PIX_W-1:0]  out_pix,
    input logic              out_last
);

    // queue plus multiply stage plus output register
    localparam int MAX_INFLIGHT = Q_DEPTH + 2;
    localparam int FL_W         = $clog2(MAX_INFLIGHT + 2);

    logic [FL_W-1:0] inflight_reg, inflight_next;
    logic            in_acc, out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_acc && !out_acc)
        begin
            inflight_next = inflight_reg + FL_W'(1);
        end
        else if (out_acc && !in_acc)
        begin
            inflight_next = inflight_reg - FL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable({out_we, out_addr, out_pix, out_last}))
        else $error("result changed while stalled");

    a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_we |-> out_addr == '0 && out_pix == '0)
        else $error("skipped pixel carries nonzero address or data");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> inflight_reg != '0)
        else $error("result without a pending request");

    a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= FL_W'(MAX_INFLIGHT))
        else $error("more requests in flight than pipeline capacity");

endmodule

bind clipped_alpha_blitter_top cab_checker u_cab_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pix_in.valid),
    .in_ready  (pix_in.ready),
    .out_valid (pix_out.valid),
    .out_ready (pix_out.ready),
    .out_we    (pix_out.write_enable),
    .out_addr  (pix_out.dest_address),
    .out_pix   (pix_out.out_pixel),
    .out_last  (pix_out.last)
);

FILE: tb/sv/tb_top.sv
// self-checking testbench of the clipped ARGB8888 alpha blitter
`timescale 1ns / 100ps

module tb_top;
    import cab_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int MAX_DIM      = 4096;
    localparam int PIPE_CYCLES  = 4;        // queue slot, multiply stage, output register
    localparam int DRAIN_CYCLES = 12;
    localparam int LIMIT_CYCLES = 600000;
    localparam int PRINT_CAP    = 40;

    // index beyond the register file, written to check that it is ignored
    localparam logic [IDX_W-1:0] REG_UNUSED_IDX = 3'd7;
    // mode code outside the three defined modes, behaves as a plain copy
    localparam logic [1:0]       MODE_SPARE     = 2'd3;

    // one predicted write request on the output channel
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  pixel;
        logic              last;
    } blit_write_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [XY_W-1:0]  cfg_data;

    cab_in_if  pix_in ();
    cab_out_if pix_out ();

    clipped_alpha_blitter_top #(
        .MAX_DIM (MAX_DIM)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_in    (pix_in.sink),
        .pix_out   (pix_out.source)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // shadow copy of the register file and of the raster position
    logic [XY_W-1:0] shadow_dest_w;
    logic [XY_W-1:0] shadow_dest_h;
    logic [XY_W-1:0] shadow_place_x;
    logic [XY_W-1:0] shadow_place_y;
    logic [XY_W-1:0] shadow_src_w;
    logic [XY_W-1:0] shadow_src_h;
    logic [1:0]      shadow_mode;
    int unsigned     cur_row;
    int unsigned     cur_col;

    // writes predicted but not yet seen on pix_out, oldest first
    blit_write_t pending_writes[$];

    // pacing controls shared between the test tasks and the sink process
    bit          src_idle_on;
    bit          sink_idle_on;
    int unsigned sink_hold_cycles;

    // bookkeeping
    int unsigned mismatches;
    int unsigned items_sent;
    int unsigned results_seen;
    int unsigned setups_applied;
    int unsigned clipped_seen;
    int unsigned keyed_out_seen;
    int unsigned blended_seen;
    int unsigned rects_done;
    int unsigned input_held;
    int unsigned cycle_count;

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // sizes saturate to 1 .. MAX_DIM
    function automatic int unsigned sat_dim(input logic [XY_W-1:0] v);
        if (v == '0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return v;
    endfunction

    // per channel floor((a*s + (255-a)*d) / 255), alpha forced opaque
    function automatic logic [PIX_W-1:0] blend_argb(input logic [PIX_W-1:0] src,
                                                  input logic [PIX_W-1:0] dst);
        int unsigned a;
        logic [PIX_W-1:0] res;
        a = src[31:24];
        res[31:24] = CH_MAX;
        for (int i = 0; i < 3; i++)
        begin
            res[i*CH_W +: CH_W] =
                CH_W'((a * src[i*CH_W +: CH_W] + (255 - a) * dst[i*CH_W +: CH_W]) / 255);
        end
        return res;
    endfunction

    // work out the write caused by one accepted pixel and step the raster
    task automatic predict_write(input logic [PIX_W-1:0] src, input logic [PIX_W-1:0] dst);
        blit_write_t w;
        int unsigned dw, dh, sw, sh;
        int px, py, cx, cy;
        bit on_surface;
        dw = sat_dim(shadow_dest_w);
        dh = sat_dim(shadow_dest_h);
        sw = sat_dim(shadow_src_w);
        sh = sat_dim(shadow_src_h);
        px = $signed(shadow_place_x);
        py = $signed(shadow_place_y);
        cx = px + int'(cur_col);
        cy = py + int'(cur_row);
        on_surface = cx >= 0 && cy >= 0 && cx < int'(dw) && cy < int'(dh);

        w = '0;
        w.last = (cur_col + 1 >= sw) && (cur_row + 1 >= sh);
        // keyed copy drops fully transparent source pixels
        w.we = on_surface && !(shadow_mode == MODE_KEYED && src[31:24] == 8'h00);
        if (w.we)
        begin
            w.addr  = ADDR_W'(cy * int'(dw) + cx);
            w.pixel = (shadow_mode == MODE_BLEND) ? blend_argb(src, dst) : src;
        end

        if (!on_surface)
            clipped_seen++;
        else if (!w.we)
            keyed_out_seen++;
        else if (shadow_mode == MODE_BLEND)
            blended_seen++;
        if (w.last)
            rects_done++;
        pending_writes.push_back(w);

        cur_col++;
        if (cur_col >= sw)
        begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= sh)
                cur_row = 0;
        end
    endtask

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // compare one accepted write request with the oldest prediction
    task automatic check_write();
        blit_write_t want;
        results_seen++;
        if (pending_writes.size() == 0)
        begin
            report_mismatch($sformatf("write request %0d arrived with none pending",
                                      results_seen));
            return;
        end
        want = pending_writes.pop_front();
        if (pix_out.write_enable !== want.we)
            report_mismatch($sformatf("request %0d write_enable %b, want %b",
                                      results_seen, pix_out.write_enable, want.we));
        if (pix_out.dest_address !== want.addr)
            report_mismatch($sformatf("request %0d dest_address %h, want %h",
                                      results_seen, pix_out.dest_address, want.addr));
        if (pix_out.out_pixel !== want.pixel)
            report_mismatch($sformatf("request %0d out_pixel %h, want %h",
                                      results_seen, pix_out.out_pixel, want.pixel));
        if (pix_out.last !== want.last)
            report_mismatch($sformatf("request %0d last %b, want %b",
                                      results_seen, pix_out.last, want.last));
    endtask

    // outputs are sampled at the edge, before any update of this step lands
    always @(posedge clk)
    begin
        if (rst_n && pix_out.valid && pix_out.ready)
            check_write();
    end

    // cycles in which the blitter refused an offered pixel
    always @(posedge clk)
    begin
        if (rst_n && pix_in.valid && !pix_in.ready)
            input_held++;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d writes still pending",
                     cycle_count, pending_writes.size());
            $display("** clipped_alpha_blitter_top: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // pacing
    // ------------------------------------------------------------------

    // mostly no gap, often a short one, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // sink side: random stalls, plus one long hold-off when a test asks for it
    initial
    begin : sink_pacing
        int unsigned hold;
        pix_out.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (sink_hold_cycles != 0)
            begin
                hold = sink_hold_cycles;
                sink_hold_cycles = 0;
            end
            else if (sink_idle_on)
                hold = pick_gap();
            else
                hold = 0;
            if (hold != 0)
            begin
                pix_out.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            pix_out.ready <= 1'b1;
            @(posedge clk);
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // offer one pixel pair and wait until it is taken; valid stays high on
    // return so that a following request can go out back to back
    task automatic send_pixel(input logic [PIX_W-1:0] src, input logic [PIX_W-1:0] dst);
        int unsigned gap;
        gap = src_idle_on ? pick_gap() : 0;
        if (gap != 0)
        begin
            pix_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_in.valid     <= 1'b1;
        pix_in.src_pixel <= src;
        pix_in.dst_pixel <= dst;
        do
            @(posedge clk);
        while (!pix_in.ready);
        predict_write(src, dst);
        items_sent++;
    endtask

    // stop offering, let every pending write come out, then let the pipe settle
    task automatic wait_idle();
        pix_in.valid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (PIPE_CYCLES) @(posedge clk);
    endtask

    // one register write; cfg_we is left high so writes can go back to back
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [XY_W-1:0] val);
        bit restart;
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        restart = 1'b1;
        case (idx)
            REG_DEST_WIDTH:  shadow_dest_w  = val;
            REG_DEST_HEIGHT: shadow_dest_h  = val;
            REG_PLACE_X:     shadow_place_x = val;
            REG_PLACE_Y:     shadow_place_y = val;
            REG_SRC_WIDTH:   shadow_src_w   = val;
            REG_SRC_HEIGHT:  shadow_src_h   = val;
            REG_BLIT_MODE:   shadow_mode    = val[1:0];
            default:         restart = 1'b0;
        endcase
        // any real register write starts the rectangle over
        if (restart)
        begin
            cur_row = 0;
            cur_col = 0;
        end
    endtask

    // full register setup, done only with nothing in flight
    task automatic setup_blit(input int dw, input int dh, input int px, input int py,
                              input int sw, input int sh, input logic [1:0] mode);
        wait_idle();
        write_reg(REG_DEST_WIDTH,  XY_W'(dw));
        write_reg(REG_DEST_HEIGHT, XY_W'(dh));
        write_reg(REG_PLACE_X,     XY_W'(px));
        write_reg(REG_PLACE_Y,     XY_W'(py));
        write_reg(REG_SRC_WIDTH,   XY_W'(sw));
        write_reg(REG_SRC_HEIGHT,  XY_W'(sh));
        write_reg(REG_BLIT_MODE,   XY_W'(mode));
        cfg_we <= 1'b0;
        setups_applied++;
    endtask

    // random ARGB value with fully transparent and fully opaque alpha favored
    function automatic logic [PIX_W-1:0] rand_argb();
        logic [PIX_W-1:0] p;
        p = $urandom;
        case ($urandom_range(0, 7))
            0:       p[31:24] = 8'h00;
            1:       p[31:24] = 8'hff;
            default: ;
        endcase
        return p;
    endfunction

    function automatic int pick_extreme_dim();
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return 1;
            2:       return MAX_DIM;
            3:       return 8191;
            default: return $urandom_range(0, 8191);
        endcase
    endfunction

    function automatic int pick_extreme_place();
        case ($urandom_range(0, 3))
            0:       return -4096;
            1:       return 4095;
            2:       return 0;
            default: return int'($urandom_range(0, 8191)) - 4096;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // 3x2 rectangle hanging off the top left corner of a 2x2 surface:
    // the whole first row and the first column are clipped
    task automatic test_clip_and_copy();
        setup_blit(2, 2, -1, -1, 3, 2, MODE_COPY);
        send_pixel(32'h1234_5678, 32'hedcb_a987);
        send_pixel(32'h8000_0001, 32'h7fff_fffe);
        send_pixel(32'h00ff_00ff, 32'hff00_ff00);
        send_pixel(32'h5555_aaaa, 32'haaaa_5555);
        send_pixel(32'hffff_ffff, 32'h0000_0000);
        send_pixel(32'h0000_0000, 32'hffff_ffff);
    endtask

    // blend at alpha 0, 255, near half and 1
    task automatic test_blend_extremes();
        setup_blit(64, 64, 3, 2, 4, 1, MODE_BLEND);
        send_pixel(32'h00ff_ffff, 32'h0012_3456);
        send_pixel(32'hff00_0000, 32'h00ff_ffff);
        send_pixel(32'h80ff_00ff, 32'h7f00_ff00);
        send_pixel(32'h01ab_cdef, 32'hff12_3456);
    endtask

    // keyed copy: alpha zero is skipped, alpha one is written
    task automatic test_keyed_copy();
        setup_blit(64, 64, 0, 0, 2, 1, MODE_KEYED);
        send_pixel(32'h00ff_ffff, 32'h1111_1111);
        send_pixel(32'h0100_0000, 32'h2222_2222);
    endtask

    // the unused mode code falls back to plain copy
    task automatic test_spare_mode();
        setup_blit(64, 64, 5, 7, 1, 1, MODE_SPARE);
        send_pixel(32'h8012_3456, 32'h00ab_cdef);
    endtask

    // zero and oversized dimensions saturate, placement at both signed ends
    task automatic test_size_saturation();
        // zero width surface acts as one column, zero sized rectangle as one pixel
        setup_blit(0, 8, 0, 5, 0, 0, MODE_COPY);
        send_pixel(32'hdead_beef, 32'h0000_0000);
        // bottom right corner of the largest surface, highest address
        setup_blit(8191, 8191, 4095, 4095, 8191, 8191, MODE_COPY);
        send_pixel(32'hcafe_f00d, 32'h1234_5678);
        // most negative placement is always off the surface
        setup_blit(MAX_DIM, MAX_DIM, -4096, -4096, 1, 1, MODE_BLEND);
        send_pixel(32'hffff_ffff, 32'hffff_ffff);
    endtask

    // a write to the unused index keeps the raster position, a real write restarts it
    task automatic test_restart_on_write();
        setup_blit(16, 16, 1, 1, 3, 3, MODE_COPY);
        send_pixel(32'h0a0a_0a0a, 32'h0);
        send_pixel(32'h0b0b_0b0b, 32'h0);
        wait_idle();
        write_reg(REG_UNUSED_IDX, 13'h1fff);
        cfg_we <= 1'b0;
        send_pixel(32'h0c0c_0c0c, 32'h0);
        wait_idle();
        write_reg(REG_PLACE_X, XY_W'(1));
        cfg_we <= 1'b0;
        send_pixel(32'h0d0d_0d0d, 32'h0);
    endtask

    // long sink hold-off while pixels keep coming: the queue fills and input stalls
    task automatic test_backpressure();
        setup_blit(16, 16, 2, 3, 5, 4, MODE_BLEND);
        src_idle_on = 1'b0;
        sink_hold_cycles = 80;
        for (int i = 0; i < 40; i++)
        begin
            send_pixel(rand_argb(), $urandom);
        end
        src_idle_on = 1'b1;
    endtask

    // random setups, mostly small surfaces and rectangles that complete a few
    // times over, with now and then extreme sizes and placements
    task automatic test_random_rectangles(input int unsigned target);
        int unsigned sent, n, area;
        int dw, dh, px, py, sw, sh;
        logic [1:0] mode;
        sent = 0;
        while (sent < target)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                dw = pick_extreme_dim();
                dh = pick_extreme_dim();
                px = pick_extreme_place();
                py = pick_extreme_place();
            end
            else
            begin
                dw = $urandom_range(1, 24);
                dh = $urandom_range(1, 24);
                px = int'($urandom_range(0, 40)) - 10;
                py = int'($urandom_range(0, 40)) - 10;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                sw = pick_extreme_dim();
                sh = pick_extreme_dim();
            end
            else
            begin
                sw = $urandom_range(1, 8);
                sh = $urandom_range(1, 8);
            end
            mode = 2'($urandom_range(0, 3));

            // idle patterns change per setup, some setups run flat out
            src_idle_on  = $urandom_range(0, 3) != 0;
            sink_idle_on = $urandom_range(0, 3) != 0;

            setup_blit(dw, dh, px, py, sw, sh, mode);
            if ($urandom_range(0, 5) == 0)
            begin
                write_reg(REG_UNUSED_IDX, XY_W'($urandom));
                cfg_we <= 1'b0;
            end

            area = sat_dim(XY_W'(sw)) * sat_dim(XY_W'(sh));
            if (area <= 64)
                n = area * $urandom_range(1, 3) + $urandom_range(0, 2);
            else
                n = $urandom_range(5, 60);
            if (n > 150)
                n = 150;
            for (int i = 0; i < n; i++)
            begin
                send_pixel(rand_argb(), $urandom);
            end
            sent += n;
        end
    endtask

    // ------------------------------------------------------------------
    // run
    // ------------------------------------------------------------------

    initial
    begin : run_tests
        // register defaults after reset
        shadow_dest_w    = 13'd1024;
        shadow_dest_h    = 13'd768;
        shadow_place_x   = '0;
        shadow_place_y   = '0;
        shadow_src_w     = 13'd16;
        shadow_src_h     = 13'd16;
        shadow_mode      = MODE_COPY;
        cur_row          = 0;
        cur_col          = 0;
        src_idle_on      = 1'b1;
        sink_idle_on     = 1'b1;
        sink_hold_cycles = 0;
        mismatches       = 0;
        items_sent       = 0;
        results_seen     = 0;
        setups_applied   = 0;
        clipped_seen     = 0;
        keyed_out_seen   = 0;
        blended_seen     = 0;
        rects_done       = 0;
        input_held       = 0;
        cycle_count      = 0;

        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= '0;
        cfg_data         <= '0;
        pix_in.valid     <= 1'b0;
        pix_in.src_pixel <= '0;
        pix_in.dst_pixel <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_clip_and_copy();
        test_blend_extremes();
        test_keyed_copy();
        test_spare_mode();
        test_size_saturation();
        test_restart_on_write();
        test_backpressure();
        test_random_rectangles(1700);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_writes.size() != 0)
            report_mismatch($sformatf("%0d predicted writes never came out",
                                      pending_writes.size()));

        $display("%0d pixels over %0d register setups: %0d clipped, %0d keyed out, %0d blended",
                 items_sent, setups_applied, clipped_seen, keyed_out_seen, blended_seen);
        $display("%0d rectangles completed, input refused for %0d cycles, %0d mismatches",
                 rects_done, input_held, mismatches);
        if (mismatches == 0)
            $display("** clipped_alpha_blitter_top: PASSED **");
        else
            $display("** clipped_alpha_blitter_top: FAILED **");
        $finish;
    end

endmodule

FILE: clipped_alpha_blitter_top.f
rtl/cab_pkg.sv
rtl/cab_if.sv
rtl/cab_queue.sv
rtl/cab_front.sv
rtl/cab_back.sv
rtl/clipped_alpha_blitter_top.sv
rtl/cab_checker.sv
tb/sv/tb_top.sv
